// ----- hw/rtl/pixel_format_to_rgb_core_defines.svh -----
// Assertion macros shared by the checker of the pixel format converter.
`ifndef PIXEL_FORMAT_TO_RGB_CORE_DEFINES_SVH
`define PIXEL_FORMAT_TO_RGB_CORE_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define PFRGB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define PFRGB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/pfrgb_pkg.sv -----
// Package with the types, mode codes and fixed-point constants of the pixel format converter.
package pfrgb_pkg;

	localparam int unsigned SAMPLE_W = 8;
	localparam int unsigned MODE_W   = 2;
	localparam int unsigned ACC_W    = 28;

	localparam logic [MODE_W-1:0] MODE_YCC420 = 2'd0;
	localparam logic [MODE_W-1:0] MODE_GREY   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RGB    = 2'd2;

	localparam logic signed [ACC_W-1:0] COEF_RV = 28'sd91881;
	localparam logic signed [ACC_W-1:0] COEF_GU = 28'sd22554;
	localparam logic signed [ACC_W-1:0] COEF_GV = 28'sd46802;
	localparam logic signed [ACC_W-1:0] COEF_BU = 28'sd116130;

	localparam logic [SAMPLE_W:0]   CHROMA_OFFSET = 9'd128;
	localparam logic [SAMPLE_W-1:0] CHAN_MAX      = 8'd255;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sa;
		logic [SAMPLE_W-1:0] sb;
		logic [SAMPLE_W-1:0] sc;
	} pfrgb_pix_t;

	// Floors a Q16 sum and saturates it to one 8-bit channel.
	function automatic logic [SAMPLE_W-1:0] clamp_q16(input logic signed [ACC_W-1:0] s);
		logic [SAMPLE_W-1:0] res;
		if (s[ACC_W-1]) begin
			res = '0;
		end else if (|s[ACC_W-2:16+SAMPLE_W]) begin
			res = CHAN_MAX;
		end else begin
			res = s[16+SAMPLE_W-1:16];
		end
		return res;
	endfunction

endpackage

// ----- hw/rtl/pfrgb_in_reg.sv -----
// Input register stage with the chroma hold for the pixel format converter.
module pfrgb_in_reg
	import pfrgb_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic [MODE_W-1:0]   format_mode,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [SAMPLE_W-1:0] sample_a,
	input  logic [SAMPLE_W-1:0] sample_b,
	input  logic [SAMPLE_W-1:0] sample_c,
	input  logic                take_chroma,
	input  logic                s2_free,
	output logic                valid_s1,
	output pfrgb_pix_t          pix_s1
);

	logic [SAMPLE_W-1:0] held_cb_q;
	logic [SAMPLE_W-1:0] held_cr_q;
	logic                accept;
	logic                latch;
	pfrgb_pix_t          pix_next;

	assign in_stall = valid_s1 & ~s2_free;
	assign accept   = in_valid & ~in_stall;
	assign latch    = (format_mode == MODE_YCC420) & take_chroma;

	always_comb begin
		pix_next.sa = sample_a;
		pix_next.sb = sample_b;
		pix_next.sc = sample_c;
		if ((format_mode == MODE_YCC420) && !take_chroma) begin
			pix_next.sb = held_cb_q;
			pix_next.sc = held_cr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cb_q <= '0;
			held_cr_q <= '0;
			valid_s1  <= 1'b0;
		end else begin
			if (accept && latch) begin
				held_cb_q <= sample_b;
				held_cr_q <= sample_c;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s2_free) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= pix_next;
		end
	end

endmodule

// ----- hw/rtl/pfrgb_convert_reg.sv -----
// Color conversion logic and result register of the pixel format converter.
module pfrgb_convert_reg
	import pfrgb_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic [MODE_W-1:0]   format_mode,
	input  logic                valid_s1,
	input  pfrgb_pix_t          pix_s1,
	output logic                s2_free,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [SAMPLE_W-1:0] red,
	output logic [SAMPLE_W-1:0] green,
	output logic [SAMPLE_W-1:0] blue
);

	logic [SAMPLE_W:0]          u_raw;
	logic [SAMPLE_W:0]          v_raw;
	logic signed [ACC_W-1:0]    u_w;
	logic signed [ACC_W-1:0]    v_w;
	logic signed [ACC_W-1:0]    y_w;
	logic signed [ACC_W-1:0]    sum_r;
	logic signed [ACC_W-1:0]    sum_g;
	logic signed [ACC_W-1:0]    sum_b;
	logic [SAMPLE_W-1:0]        red_next;
	logic [SAMPLE_W-1:0]        green_next;
	logic [SAMPLE_W-1:0]        blue_next;

	assign s2_free = ~out_valid | ~out_stall;

	assign u_raw = {1'b0, pix_s1.sb} - CHROMA_OFFSET;
	assign v_raw = {1'b0, pix_s1.sc} - CHROMA_OFFSET;
	assign u_w   = {{(ACC_W-SAMPLE_W-1){u_raw[SAMPLE_W]}}, u_raw};
	assign v_w   = {{(ACC_W-SAMPLE_W-1){v_raw[SAMPLE_W]}}, v_raw};
	assign y_w   = {{(ACC_W-SAMPLE_W-16){1'b0}}, pix_s1.sa, 16'd0};

	assign sum_r = y_w + COEF_RV * v_w;
	assign sum_g = y_w - COEF_GU * u_w - COEF_GV * v_w;
	assign sum_b = y_w + COEF_BU * u_w;

	always_comb begin
		case (format_mode)
			MODE_YCC420: begin
				red_next   = clamp_q16(sum_r);
				green_next = clamp_q16(sum_g);
				blue_next  = clamp_q16(sum_b);
			end
			MODE_GREY: begin
				red_next   = pix_s1.sa;
				green_next = pix_s1.sa;
				blue_next  = pix_s1.sa;
			end
			MODE_RGB: begin
				red_next   = pix_s1.sa;
				green_next = pix_s1.sb;
				blue_next  = pix_s1.sc;
			end
			default: begin
				red_next   = '0;
				green_next = '0;
				blue_next  = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s2_free) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && valid_s1) begin
			red   <= red_next;
			green <= green_next;
			blue  <= blue_next;
		end
	end

endmodule

// ----- hw/rtl/pixel_format_to_rgb_core.sv -----
// Top level of the pixel format converter from YCbCr, grey or RGB samples to RGB.
//
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   sample_a, sample_b, sample_c, take_chroma
// output    out        out_valid / out_stall red, green, blue
// config    in         cfg_wr_en             cfg_wr_data (format mode)
//
// One transaction per clock is sustained while the output is not stalled; an accepted input
// passes through the input register and then the result register before out_valid shows it.
// The rate is set by the single pass through the constant multiplies, the sums and the
// clamp between the input register and the result register.
// Reset clears the valid flags, the held chroma and the format mode.
// A stalled output holds its transaction; the input stalls only when both stages are full
// and the output is stalled.
module pixel_format_to_rgb_core
	import pfrgb_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [MODE_W-1:0]   cfg_wr_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [SAMPLE_W-1:0] sample_a,
	input  logic [SAMPLE_W-1:0] sample_b,
	input  logic [SAMPLE_W-1:0] sample_c,
	input  logic                take_chroma,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [SAMPLE_W-1:0] red,
	output logic [SAMPLE_W-1:0] green,
	output logic [SAMPLE_W-1:0] blue
);

	logic [MODE_W-1:0] format_mode_q;
	logic              valid_s1;
	logic              s2_free;
	pfrgb_pix_t        pix_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_mode_q <= MODE_YCC420;
		end else if (cfg_wr_en) begin
			format_mode_q <= cfg_wr_data;
		end
	end

	pfrgb_in_reg u_in_reg (
		.clk         (clk),
		.arst_n      (arst_n),
		.format_mode (format_mode_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample_a    (sample_a),
		.sample_b    (sample_b),
		.sample_c    (sample_c),
		.take_chroma (take_chroma),
		.s2_free     (s2_free),
		.valid_s1    (valid_s1),
		.pix_s1      (pix_s1)
	);

	pfrgb_convert_reg u_convert_reg (
		.clk         (clk),
		.arst_n      (arst_n),
		.format_mode (format_mode_q),
		.valid_s1    (valid_s1),
		.pix_s1      (pix_s1),
		.s2_free     (s2_free),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.red         (red),
		.green       (green),
		.blue        (blue)
	);

endmodule

// ----- hw/rtl/pfrgb_checker.sv -----
// Port-level assertion checker for the pixel format converter and its bind statement.
`include "pixel_format_to_rgb_core_defines.svh"

module pfrgb_checker
	import pfrgb_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input logic [SAMPLE_W-1:0] red,
	input logic [SAMPLE_W-1:0] green,
	input logic [SAMPLE_W-1:0] blue
);

	`PFRGB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled output dropped")
	`PFRGB_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(red) && $stable(green) && $stable(blue), "stalled output changed")
	`PFRGB_ASSERT_NOW(a_in_stall_cause, in_stall, out_valid && out_stall, "input stalled without output stall")
	`PFRGB_ASSERT_NOW(a_out_origin, $rose(out_valid), $past(in_valid && !in_stall, 2), "output without input")

endmodule

bind pixel_format_to_rgb_core pfrgb_checker u_pfrgb_checker (.*);
